FILE: rtl/arbw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adaptive Rice bit writer package
// Shared types, codes and constants for the command front end, the job
// queue and the bit packer.
// ----------------------------------------------------------------------------
package arbw_pkg;

   // Defaults for the top-level parameters
   localparam int DEF_NUM_CONTEXTS = 16;
   localparam int DEF_MAX_PREFIX   = 255;

   // Field widths
   localparam int K_W    = 4;   // adaptive k
   localparam int ONES_W = 9;   // unary prefix length, covers the largest prefix limit
   localparam int TAIL_W = 17;  // terminator plus up to 16 suffix bits
   localparam int TLEN_W = 5;   // tail length 0..17

   localparam logic [K_W-1:0]    K_MAX        = 4'd15;
   localparam logic [K_W-1:0]    INIT_K_RESET = 4'd2;
   localparam logic [TLEN_W-1:0] RAW_MAX      = 5'd16;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_INITIAL_K = 1'b0;

   // Command codes
   typedef enum logic [2:0] {
      OP_RAW          = 3'd0,
      OP_RICE         = 3'd1,
      OP_RICE_SIGNED  = 3'd2,
      OP_ADAPT        = 3'd3,
      OP_ADAPT_SIGNED = 3'd4,
      OP_FLUSH        = 3'd5
   } op_type;

   // Job kinds handed from front to back
   typedef enum logic [1:0] {
      JOB_BITS  = 2'd0,
      JOB_FLUSH = 2'd1,
      JOB_ERROR = 2'd2
   } job_kind_type;

   // One queued job: a run of ones followed by a left-aligned tail
   typedef struct packed {
      job_kind_type      kind;
      logic [ONES_W-1:0] ones;
      logic [TAIL_W-1:0] tail;
      logic [TLEN_W-1:0] tlen;
   } job_type;

   // Configuration update toward the front end
   typedef struct packed {
      logic           load;
      logic [K_W-1:0] k;
   } cfg_type;

endpackage

FILE: rtl/arbw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command front end
// Accepts a command, looks up the context k, computes the Rice quotient,
// checks the prefix limit, updates the context table and queues a bit job.
// ----------------------------------------------------------------------------
module arbw_front
   import arbw_pkg::*;
#(
   parameter int NUM_CONTEXTS = DEF_NUM_CONTEXTS,
   parameter int MAX_PREFIX   = DEF_MAX_PREFIX
) (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [2:0]        req_op,
   input  logic signed [16:0] req_value,
   input  logic [4:0]        req_nbits,
   input  logic [3:0]        req_context_req,
   output logic              job_valid,
   input  logic              job_ready,
   output job_type           job_data
);

   localparam int CTX_W = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;

   typedef enum logic [1:0] {
      FS_IDLE = 2'b01,
      FS_CALC = 2'b10
   } fstate_type;

   fstate_type          state_ff, state_in;
   logic [2:0]          op_ff, op_in;
   logic [16:0]         value_ff, value_in;
   logic [TLEN_W-1:0]   nb_ff, nb_in;
   logic [CTX_W-1:0]    idx_ff, idx_in;
   logic [CTX_W-1:0]    idx_sel;
   logic [K_W-1:0]      k_mem_ff [NUM_CONTEXTS];
   logic [NUM_CONTEXTS-1:0] kval_ff;
   logic [K_W-1:0]      krd_ff;
   logic                kvrd_ff;
   logic                accept;
   logic                k_wr;

   logic                is_signed;
   logic                is_adapt;
   logic [17:0]         zz;
   logic [16:0]         u;
   logic [K_W-1:0]      k_ctx;
   logic [TLEN_W-1:0]   k_use;
   logic [16:0]         q;
   logic                err;
   logic [3:0]          lg;
   logic [4:0]          k_sum;
   logic [K_W-1:0]      k_new;
   logic [16:0]         k_mask;
   logic [16:0]         nb_mask;
   logic [16:0]         raw_bits;

   // Clamp the context index to the table
   always_comb begin
      if (int'(req_context_req) >= NUM_CONTEXTS) begin
         idx_sel = CTX_W'(NUM_CONTEXTS - 1);
      end else begin
         idx_sel = CTX_W'(req_context_req);
      end
   end

   assign accept = req_valid && req_ready;

   // Decode the held command and compute the code
   always_comb begin
      is_signed = (op_type'(op_ff) == OP_RICE_SIGNED) || (op_type'(op_ff) == OP_ADAPT_SIGNED);
      is_adapt  = (op_type'(op_ff) == OP_ADAPT) || (op_type'(op_ff) == OP_ADAPT_SIGNED);
      zz        = {value_ff, 1'b0} ^ {18{value_ff[16]}};
      u         = is_signed ? zz[16:0] : {1'b0, value_ff[15:0]};
      k_ctx     = kvrd_ff ? krd_ff : cfg.k;
      k_use     = is_adapt ? {1'b0, k_ctx} : nb_ff;
      q         = u >> k_use;
      err       = q > 17'(MAX_PREFIX);
      // floor(log2 q) over the prefix range
      lg = 4'd0;
      for (int i = 0; i < ONES_W; i++) begin
         if (q[i]) begin
            lg = 4'(i);
         end
      end
      k_sum = {1'b0, k_ctx} + {1'b0, lg};
      if (q == 17'd0) begin
         k_new = (k_ctx == 4'd0) ? 4'd0 : k_ctx - 4'd1;
      end else if (q == 17'd1) begin
         k_new = k_ctx;
      end else begin
         k_new = (k_sum > {1'b0, K_MAX}) ? K_MAX : k_sum[K_W-1:0];
      end
      k_mask   = 17'((18'd1 << k_use) - 18'd1);
      nb_mask  = 17'((18'd1 << nb_ff) - 18'd1);
      raw_bits = {1'b0, value_ff[15:0]} & nb_mask;
   end

   // Build the job for the back end
   always_comb begin
      job_valid     = 1'b0;
      job_data.kind = JOB_BITS;
      job_data.ones = '0;
      job_data.tail = '0;
      job_data.tlen = '0;
      if (state_ff == FS_CALC) begin
         unique case (op_type'(op_ff)) inside
            OP_RAW: begin
               job_valid     = 1'b1;
               job_data.tail = raw_bits << (5'd17 - nb_ff);
               job_data.tlen = nb_ff;
            end
            OP_RICE, OP_RICE_SIGNED, OP_ADAPT, OP_ADAPT_SIGNED: begin
               job_valid = 1'b1;
               if (err) begin
                  job_data.kind = JOB_ERROR;
               end else begin
                  job_data.ones = q[ONES_W-1:0];
                  job_data.tail = (u & k_mask) << (5'd16 - k_use);
                  job_data.tlen = k_use + 5'd1;
               end
            end
            OP_FLUSH: begin
               job_valid     = 1'b1;
               job_data.kind = JOB_FLUSH;
            end
            default: begin
               job_valid = 1'b0;
            end
         endcase
      end
   end

   assign k_wr = (state_ff == FS_CALC) && job_ready && is_adapt && !err;

   // Sequence: take a command, then finish it once the queue takes its job
   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      value_in  = value_ff;
      nb_in     = nb_ff;
      idx_in    = idx_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         FS_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in    = req_op;
               value_in = req_value;
               nb_in    = (req_nbits > RAW_MAX) ? RAW_MAX : req_nbits;
               idx_in   = idx_sel;
               state_in = FS_CALC;
            end
         end
         FS_CALC: begin
            if (!job_valid || job_ready) begin
               state_in = FS_IDLE;
            end
         end
         default: begin
            state_in = FS_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Command hold registers
   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      value_ff <= value_in;
      nb_ff    <= nb_in;
      idx_ff   <= idx_in;
   end

   // Context table: registered read on accept, write after the code is known
   always_ff @(posedge clock) begin
      if (accept) begin
         krd_ff  <= k_mem_ff[idx_sel];
         kvrd_ff <= kval_ff[idx_sel];
      end
      if (k_wr) begin
         k_mem_ff[idx_ff] <= k_new;
      end
   end

   // Valid bits: an entry not yet written reads as the initial k
   always_ff @(posedge clock) begin
      if (reset || cfg.load) begin
         kval_ff <= '0;
      end else if (k_wr) begin
         kval_ff[idx_ff] <= 1'b1;
      end
   end

endmodule

FILE: rtl/arbw_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Job queue
// Two-entry queue of bit jobs between the front end and the bit packer.
// ----------------------------------------------------------------------------
module arbw_queue
   import arbw_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  job_type push_data,
   output logic    pop_valid,
   input  logic    pop_ready,
   output job_type pop_data
);

   job_type    ent_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   logic       pop;

   assign push_ready = (cnt_ff != 2'd2);
   assign pop_valid  = (cnt_ff != 2'd0);
   assign pop_data   = ent_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store the incoming job
   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/arbw_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit packer
// Appends each job's ones and tail to the pending bits, one chunk a cycle
// unless a full byte waits, and hands completed bytes to the output register.
// ----------------------------------------------------------------------------
module arbw_back
   import arbw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       pop_valid,
   output logic       pop_ready,
   input  job_type    pop_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_status,
   output logic       rsp_last
);

   typedef enum logic [1:0] {
      BS_LOAD = 2'b01,
      BS_RUN  = 2'b10
   } bstate_type;

   bstate_type        state_ff, state_in;
   job_kind_type      kind_ff, kind_in;
   logic [ONES_W-1:0] ones_ff, ones_in;
   logic [TAIL_W-1:0] tail_ff, tail_in;
   logic [TLEN_W-1:0] tlen_ff, tlen_in;
   logic [6:0]        pend_ff, pend_in;
   logic [2:0]        pcnt_ff, pcnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        byte_ff, byte_in;
   logic              status_ff, status_in;
   logic              last_ff, last_in;

   logic              out_free;
   logic [3:0]        need;
   logic              use_ones;
   logic [3:0]        n;
   logic [7:0]        chunk;
   logic [7:0]        acc;
   logic [3:0]        sum;
   logic [ONES_W-1:0] ones_nx;
   logic [TAIL_W-1:0] tail_nx;
   logic [TLEN_W-1:0] tlen_nx;
   logic [9:0]        rem_nx;
   logic              emit;

   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_status   = status_ff;
   assign rsp_last     = last_ff;

   // Size the next chunk: up to the byte boundary or the segment end
   always_comb begin
      need     = 4'd8 - {1'b0, pcnt_ff};
      use_ones = (ones_ff != '0);
      if (use_ones) begin
         n     = (ones_ff < ONES_W'(need)) ? ones_ff[3:0] : need;
         chunk = 8'((9'd1 << n) - 9'd1);
      end else begin
         n     = (tlen_ff < TLEN_W'(need)) ? tlen_ff[3:0] : need;
         chunk = tail_ff[TAIL_W-1 -: 8] >> (4'd8 - n);
      end
      acc     = ({1'b0, pend_ff} << n) | chunk;
      sum     = {1'b0, pcnt_ff} + n;
      ones_nx = use_ones ? ones_ff - ONES_W'(n) : ones_ff;
      tail_nx = use_ones ? tail_ff : tail_ff << n;
      tlen_nx = use_ones ? tlen_ff : tlen_ff - TLEN_W'(n);
      rem_nx  = 10'(ones_nx) + 10'(tlen_nx);
   end

   // Load jobs and run them
   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      ones_in   = ones_ff;
      tail_in   = tail_ff;
      tlen_in   = tlen_ff;
      pend_in   = pend_ff;
      pcnt_in   = pcnt_ff;
      byte_in   = byte_ff;
      status_in = status_ff;
      last_in   = last_ff;
      emit      = 1'b0;
      pop_ready = 1'b0;
      unique case (state_ff)
         BS_LOAD: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               kind_in  = pop_data.kind;
               ones_in  = pop_data.ones;
               tail_in  = pop_data.tail;
               tlen_in  = pop_data.tlen;
               state_in = BS_RUN;
            end
         end
         BS_RUN: begin
            unique case (kind_ff)
               JOB_ERROR: begin
                  if (out_free) begin
                     emit      = 1'b1;
                     byte_in   = 8'd0;
                     status_in = 1'b1;
                     last_in   = 1'b1;
                     state_in  = BS_LOAD;
                  end
               end
               JOB_FLUSH: begin
                  if (pcnt_ff == 3'd0) begin
                     state_in = BS_LOAD;
                  end else if (out_free) begin
                     emit      = 1'b1;
                     byte_in   = {1'b0, pend_ff} << (4'd8 - {1'b0, pcnt_ff});
                     status_in = 1'b0;
                     last_in   = 1'b1;
                     pend_in   = '0;
                     pcnt_in   = '0;
                     state_in  = BS_LOAD;
                  end
               end
               JOB_BITS: begin
                  // Hold while a completed byte has nowhere to go
                  if (!(sum == 4'd8) || out_free) begin
                     ones_in = ones_nx;
                     tail_in = tail_nx;
                     tlen_in = tlen_nx;
                     if (sum == 4'd8) begin
                        emit      = 1'b1;
                        byte_in   = acc;
                        status_in = 1'b0;
                        last_in   = (rem_nx < 10'd8);
                        pend_in   = '0;
                        pcnt_in   = '0;
                     end else begin
                        pend_in = acc[6:0];
                        pcnt_in = sum[2:0];
                     end
                     if (rem_nx == 10'd0) begin
                        state_in = BS_LOAD;
                     end
                  end
               end
               default: begin
                  state_in = BS_LOAD;
               end
            endcase
         end
         default: begin
            state_in = BS_LOAD;
         end
      endcase
      rsp_valid_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BS_LOAD;
         pend_ff      <= '0;
         pcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         pcnt_ff      <= pcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Job and output payload
   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      ones_ff   <= ones_in;
      tail_ff   <= tail_in;
      tlen_ff   <= tlen_in;
      byte_ff   <= byte_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

endmodule

FILE: rtl/adaptive_rice_bit_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adaptive Rice bit writer
// Packs raw bits and fixed or adaptive Rice codes MSB first into bytes.
// ----------------------------------------------------------------------------
// The front end accepts a command and reads its context k in the idle state,
// then sets up the code in the calculate state until the two-entry queue takes
// the bit job, so it takes no new command before the last job is queued. The
// bit packer loads a job in its load state and then packs one chunk a cycle,
// where a chunk ends at a byte boundary or at the end of the ones run or the
// tail, so long unary prefixes hold the input back once the queue fills.
// Errors and flushes go through the load and run states of the packer.
// Completed bytes sit in an output register, so the packer keeps going while a
// byte waits and stalls only when the next byte completes before the waiting
// one is taken. There is no clearing pass: the context table uses valid
// bits, cleared at reset and on every write of initial_k (register 0, byte
// address 0).
// ----------------------------------------------------------------------------
module adaptive_rice_bit_writer
   import arbw_pkg::*;
#(
   parameter int NUM_CONTEXTS = DEF_NUM_CONTEXTS,
   parameter int MAX_PREFIX   = DEF_MAX_PREFIX
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [2:0]            req_op,
   input  logic signed [16:0]    req_value,
   input  logic [4:0]            req_nbits,
   input  logic [3:0]            req_context_req,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_status,
   output logic                  rsp_last,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [K_W-1:0] init_k_ff, init_k_in;
   cfg_type        cfg;
   logic           job_valid;
   logic           job_ready;
   job_type        job_data;
   logic           pop_valid;
   logic           pop_ready;
   job_type        pop_data;

   assign csr_pready = 1'b1;

   // Register decode
   always_comb begin
      cfg.load   = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_paddr[2] == CSR_IDX_INITIAL_K);
      init_k_in  = cfg.load ? csr_pwdata[K_W-1:0] : init_k_ff;
      cfg.k      = init_k_ff;
      csr_prdata = (csr_paddr[2] == CSR_IDX_INITIAL_K) ?
                   CSR_DATA_W'(init_k_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_k_ff <= INIT_K_RESET;
      end else begin
         init_k_ff <= init_k_in;
      end
   end

   arbw_front #(
      .NUM_CONTEXTS (NUM_CONTEXTS),
      .MAX_PREFIX   (MAX_PREFIX)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_value       (req_value),
      .req_nbits       (req_nbits),
      .req_context_req (req_context_req),
      .job_valid       (job_valid),
      .job_ready       (job_ready),
      .job_data        (job_data)
   );

   arbw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (job_valid),
      .push_ready (job_ready),
      .push_data  (job_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   arbw_back u_back (
      .clock        (clock),
      .reset        (reset),
      .pop_valid    (pop_valid),
      .pop_ready    (pop_ready),
      .pop_data     (pop_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_status   (rsp_status),
      .rsp_last     (rsp_last)
   );

endmodule
